### sv/hex_grid_to_tet_indices_macros.svh
// Assertion helpers for the hex-to-tet splitter.
`ifndef HEX_GRID_TO_TET_INDICES_MACROS_SVH
`define HEX_GRID_TO_TET_INDICES_MACROS_SVH

// Same-cycle implication.
`define HGTT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("hgtt assertion failed");

// Next-cycle implication.
`define HGTT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("hgtt assertion failed");

`endif

### sv/hgtt_pkg.sv
`default_nettype none
package hgtt_pkg;

	localparam int IDX_W    = 25;
	localparam int VAL_W    = 16;
	localparam int REGION_W = 17;
	localparam int OFS_W    = 8;
	localparam int CREG_W   = 9;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int SLOT_W   = 3;
	localparam int NUM_TETS = 5;

	localparam logic [SLOT_W-1:0] SLOT_FIRST = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = 3'd4;

	typedef logic [2:0] corner_sel_t;

	// Corner k: x + (k in 1,2,5,6), y + (k in 2,3,6,7), z + (k >= 4)
	localparam corner_sel_t SPLIT_ODD [NUM_TETS][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd5},
		'{3'd0, 3'd2, 3'd3, 3'd7},
		'{3'd0, 3'd2, 3'd5, 3'd7},
		'{3'd0, 3'd4, 3'd5, 3'd7},
		'{3'd2, 3'd5, 3'd6, 3'd7}
	};
	localparam corner_sel_t SPLIT_EVEN [NUM_TETS][4] = '{
		'{3'd1, 3'd0, 3'd3, 3'd4},
		'{3'd1, 3'd3, 3'd2, 3'd6},
		'{3'd1, 3'd3, 3'd4, 3'd6},
		'{3'd1, 3'd5, 3'd4, 3'd6},
		'{3'd3, 3'd4, 3'd7, 3'd6}
	};

	// Fixed-width control from the register block
	typedef struct packed {
		logic             restart;
		logic             remove_air;
		logic             scalar_as_material;
		logic [OFS_W-1:0] value_offset;
	} ctrl_t;

	// One kept cell waiting to be split
	typedef struct packed {
		logic [IDX_W-1:0]           base_node;
		logic signed [REGION_W-1:0] region;
		logic                       material;
		logic                       odd;
	} cell_t;

endpackage
`default_nettype wire

### sv/hgtt_cfg.sv
`default_nettype none
module hgtt_cfg
	import hgtt_pkg::*;
#(
	parameter int MAX_CELLS_PER_AXIS = 256,
	parameter int CW = $clog2(MAX_CELLS_PER_AXIS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output logic      [CW-1:0]     cx,
	output logic      [CW-1:0]     cy,
	output logic      [CW-1:0]     cz,
	output logic      [IDX_W-1:0]  step_y,
	output logic      [IDX_W-1:0]  step_x,
	output logic      [IDX_W-1:0]  step_xy,
	output ctrl_t                  ctrl
);

	localparam logic [2:0] REG_CELLS_X  = 3'd0;
	localparam logic [2:0] REG_CELLS_Y  = 3'd1;
	localparam logic [2:0] REG_CELLS_Z  = 3'd2;
	localparam logic [2:0] REG_REM_AIR  = 3'd3;
	localparam logic [2:0] REG_MATERIAL = 3'd4;
	localparam logic [2:0] REG_OFFSET   = 3'd5;

	localparam int EW = (CW > CREG_W) ? CW : CREG_W;

	logic [CREG_W-1:0] cells_x_q, cells_y_q, cells_z_q;
	logic              remove_air_q, material_q;
	logic [OFS_W-1:0]  offset_q;
	logic              wr;
	logic [2:0]        idx;
	logic [CW:0]       cy1, cy2, cz1;
	logic [2*CW+1:0]   sx_full, sxy_full;

	function automatic logic [CW-1:0] eff(input logic [CREG_W-1:0] v);
		logic [EW-1:0] ve;
		ve = EW'(v);
		if (ve == '0)
			return CW'(1);
		else if (ve > EW'(MAX_CELLS_PER_AXIS))
			return CW'(MAX_CELLS_PER_AXIS);
		else
			return CW'(ve);
	endfunction

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q    <= CREG_W'(1);
			cells_y_q    <= CREG_W'(1);
			cells_z_q    <= CREG_W'(1);
			remove_air_q <= 1'b0;
			material_q   <= 1'b0;
			offset_q     <= '0;
		end else if (wr) begin
			case (idx)
				REG_CELLS_X:  cells_x_q    <= pwdata[CREG_W-1:0];
				REG_CELLS_Y:  cells_y_q    <= pwdata[CREG_W-1:0];
				REG_CELLS_Z:  cells_z_q    <= pwdata[CREG_W-1:0];
				REG_REM_AIR:  remove_air_q <= pwdata[0];
				REG_MATERIAL: material_q   <= pwdata[0];
				REG_OFFSET:   offset_q     <= pwdata[OFS_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CELLS_X:  prdata = DATA_W'(cells_x_q);
			REG_CELLS_Y:  prdata = DATA_W'(cells_y_q);
			REG_CELLS_Z:  prdata = DATA_W'(cells_z_q);
			REG_REM_AIR:  prdata = DATA_W'(remove_air_q);
			REG_MATERIAL: prdata = DATA_W'(material_q);
			REG_OFFSET:   prdata = DATA_W'(offset_q);
			default:      prdata = '0;
		endcase
	end

	assign cx = eff(cells_x_q);
	assign cy = eff(cells_y_q);
	assign cz = eff(cells_z_q);

	// node strides: z 1, y (cz+1), x (cy+1)(cz+1); x+y stride (cy+2)(cz+1)
	assign cy1      = (CW + 1)'(cy) + (CW + 1)'(1);
	assign cy2      = (CW + 1)'(cy) + (CW + 1)'(2);
	assign cz1      = (CW + 1)'(cz) + (CW + 1)'(1);
	assign sx_full  = (2 * CW + 2)'(cy1) * (2 * CW + 2)'(cz1);
	assign sxy_full = (2 * CW + 2)'(cy2) * (2 * CW + 2)'(cz1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_y  <= IDX_W'(2);
			step_x  <= IDX_W'(4);
			step_xy <= IDX_W'(6);
		end else begin
			step_y  <= IDX_W'(cz1);
			step_x  <= IDX_W'(sx_full);
			step_xy <= IDX_W'(sxy_full);
		end
	end

	assign ctrl.restart            = wr && (idx == REG_CELLS_X || idx == REG_CELLS_Y ||
		idx == REG_CELLS_Z);
	assign ctrl.remove_air         = remove_air_q;
	assign ctrl.scalar_as_material = material_q;
	assign ctrl.value_offset       = offset_q;

endmodule
`default_nettype wire

### sv/hgtt_scan.sv
`default_nettype none
module hgtt_scan
	import hgtt_pkg::*;
#(
	parameter int MAX_CELLS_PER_AXIS = 256,
	parameter int CW = $clog2(MAX_CELLS_PER_AXIS + 1),
	parameter int PW = $clog2(MAX_CELLS_PER_AXIS)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic      [CW-1:0]      cx,
	input  wire logic      [CW-1:0]      cy,
	input  wire logic      [CW-1:0]      cz,
	input  wire ctrl_t                   ctrl,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [VAL_W-1:0] voxel_value,
	input  wire logic                    cell_free,
	output logic                         cell_valid_s1,
	output cell_t                        cell_s1
);

	logic [PW-1:0]              pos_x_q, pos_y_q, pos_z_q;
	logic [IDX_W-1:0]           base_q;
	logic                       accept, keep;
	logic                       z_end, y_end, x_end;
	logic signed [REGION_W-1:0] region;

	assign in_ready = !cell_valid_s1 || cell_free;
	assign accept   = in_valid && in_ready;

	assign region = REGION_W'(voxel_value) - REGION_W'($signed({1'b0, ctrl.value_offset}));
	assign keep   = !(region == '0 && ctrl.remove_air);

	assign z_end = (CW'(pos_z_q) == cz - CW'(1));
	assign y_end = (CW'(pos_y_q) == cy - CW'(1));
	assign x_end = (CW'(pos_x_q) == cx - CW'(1));

	// Raster walk; base node follows by the stride jump of each wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			base_q  <= '0;
		end else if (ctrl.restart) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			base_q  <= '0;
		end else if (accept) begin
			if (!z_end) begin
				pos_z_q <= pos_z_q + PW'(1);
				base_q  <= base_q + IDX_W'(1);
			end else if (!y_end) begin
				pos_z_q <= '0;
				pos_y_q <= pos_y_q + PW'(1);
				base_q  <= base_q + IDX_W'(2);
			end else if (!x_end) begin
				pos_z_q <= '0;
				pos_y_q <= '0;
				pos_x_q <= pos_x_q + PW'(1);
				base_q  <= base_q + IDX_W'(cz) + IDX_W'(3);
			end else begin
				pos_z_q <= '0;
				pos_y_q <= '0;
				pos_x_q <= '0;
				base_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cell_valid_s1 <= 1'b0;
		else if (accept)
			cell_valid_s1 <= keep;
		else if (cell_free)
			cell_valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1.base_node <= base_q;
			cell_s1.region    <= region;
			cell_s1.material  <= ctrl.scalar_as_material;
			cell_s1.odd       <= pos_x_q[0] ^ pos_y_q[0] ^ pos_z_q[0];
		end
	end

endmodule
`default_nettype wire

### sv/hgtt_emit.sv
`default_nettype none
`include "hex_grid_to_tet_indices_macros.svh"
module hgtt_emit
	import hgtt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cell_valid_s1,
	input  wire cell_t                     cell_s1,
	input  wire logic      [IDX_W-1:0]     step_y,
	input  wire logic      [IDX_W-1:0]     step_x,
	input  wire logic      [IDX_W-1:0]     step_xy,
	output logic                           cell_free,
	output logic                           out_valid_s2,
	input  wire logic                      out_ready,
	output logic      [IDX_W-1:0]          corner_s2 [4],
	output logic      [SLOT_W-1:0]         tet_slot_s2,
	output logic signed [REGION_W-1:0]     region_s2,
	output logic                           material_s2,
	output logic                           last_tet_s2
);

	logic [SLOT_W-1:0] slot_q;
	logic              load;
	logic [IDX_W-1:0]  corner_n [4];

	// node of corner k relative to the cell's low corner
	function automatic logic [IDX_W-1:0] corner_node(
		input logic [IDX_W-1:0] base,
		input corner_sel_t      sel,
		input logic [IDX_W-1:0] sy,
		input logic [IDX_W-1:0] sx,
		input logic [IDX_W-1:0] sxy
	);
		logic [IDX_W-1:0] ofs;
		case ({sel[0] ^ sel[1], sel[1]})
			2'b10:   ofs = sx;
			2'b11:   ofs = sxy;
			2'b01:   ofs = sy;
			default: ofs = '0;
		endcase
		return base + ofs + IDX_W'(sel[2]);
	endfunction

	assign load      = cell_valid_s1 && (!out_valid_s2 || out_ready);
	assign cell_free = load && (slot_q == SLOT_LAST);

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			corner_n[j] = corner_node(cell_s1.base_node,
				cell_s1.odd ? SPLIT_ODD[slot_q][j] : SPLIT_EVEN[slot_q][j],
				step_y, step_x, step_xy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= SLOT_FIRST;
			out_valid_s2 <= 1'b0;
		end else begin
			if (load)
				slot_q <= (slot_q == SLOT_LAST) ? SLOT_FIRST : slot_q + SLOT_W'(1);
			if (load)
				out_valid_s2 <= 1'b1;
			else if (out_ready)
				out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			corner_s2   <= corner_n;
			tet_slot_s2 <= slot_q;
			region_s2   <= cell_s1.region;
			material_s2 <= cell_s1.material;
			last_tet_s2 <= (slot_q == SLOT_LAST);
		end
	end

	`HGTT_ASSERT_NOW(a_last_matches_slot, clk, arst_n, out_valid_s2, last_tet_s2 == (tet_slot_s2 == SLOT_LAST))
	`HGTT_ASSERT_NOW(a_slot_in_range, clk, arst_n, 1'b1, slot_q <= SLOT_LAST)
	`HGTT_ASSERT_NOW(a_empty_slot_zero, clk, arst_n, !cell_valid_s1, slot_q == SLOT_FIRST)
	`HGTT_ASSERT_NEXT(a_release_marks_last, clk, arst_n, cell_free, out_valid_s2 && last_tet_s2)

endmodule
`default_nettype wire

### sv/hex_grid_to_tet_indices.sv
// Channel   Handshake               Payload
// voxel in  in_valid / in_ready     voxel_value
// tet out   out_valid / out_ready   corner_a..d, tet_slot, region_value, material_applied, last_tet
// config    APB psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// A kept cell gives five tetrahedra, one per cycle from the output register while out_ready
// is high; the slot counter of the emitter steps through them. A skipped (air) cell is not held
// and gives no tetrahedra. A kept cell is registered first, then split into the output register.
// The next voxel is taken in the cycle the fifth tetrahedron of the held cell is loaded.
// Reset (arst_n low) clears registers to 1x1x1 cells, origin scan position, no valid transactions.
// A stalled output holds the result; the held cell waits and in_ready drops until it is split.
`default_nettype none
module hex_grid_to_tet_indices
	import hgtt_pkg::*;
#(
	parameter int MAX_CELLS_PER_AXIS = 256
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic      [ADDR_W-1:0]    paddr,
	input  wire logic      [DATA_W-1:0]    pwdata,
	output logic      [DATA_W-1:0]         prdata,
	output logic                           pready,
	// voxel stream
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [VAL_W-1:0]   voxel_value,
	// tetrahedron stream
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [IDX_W-1:0]          corner_a,
	output logic      [IDX_W-1:0]          corner_b,
	output logic      [IDX_W-1:0]          corner_c,
	output logic      [IDX_W-1:0]          corner_d,
	output logic      [SLOT_W-1:0]         tet_slot,
	output logic signed [REGION_W-1:0]     region_value,
	output logic                           material_applied,
	output logic                           last_tet
);

	// effective extent width (holds MAX itself) and scan position width
	localparam int CW = $clog2(MAX_CELLS_PER_AXIS + 1);
	localparam int PW = $clog2(MAX_CELLS_PER_AXIS);

	logic [CW-1:0]    cx, cy, cz;
	logic [IDX_W-1:0] step_y, step_x, step_xy;
	ctrl_t            ctrl;
	logic             cell_valid_s1, cell_free;
	cell_t            cell_s1;
	logic [IDX_W-1:0] corner_s2 [4];

	// register block: extents are clamped here, strides registered
	hgtt_cfg #(
		.MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS),
		.CW(CW)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cx      (cx),
		.cy      (cy),
		.cz      (cz),
		.step_y  (step_y),
		.step_x  (step_x),
		.step_xy (step_xy),
		.ctrl    (ctrl)
	);

	// raster walk, region value, air drop; holds one kept cell
	hgtt_scan #(
		.MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS),
		.CW(CW),
		.PW(PW)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cx            (cx),
		.cy            (cy),
		.cz            (cz),
		.ctrl          (ctrl),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.voxel_value   (voxel_value),
		.cell_free     (cell_free),
		.cell_valid_s1 (cell_valid_s1),
		.cell_s1       (cell_s1)
	);

	// five-slot splitter into the output register
	hgtt_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.cell_valid_s1 (cell_valid_s1),
		.cell_s1       (cell_s1),
		.step_y        (step_y),
		.step_x        (step_x),
		.step_xy       (step_xy),
		.cell_free     (cell_free),
		.out_valid_s2  (out_valid),
		.out_ready     (out_ready),
		.corner_s2     (corner_s2),
		.tet_slot_s2   (tet_slot),
		.region_s2     (region_value),
		.material_s2   (material_applied),
		.last_tet_s2   (last_tet)
	);

	assign corner_a = corner_s2[0];
	assign corner_b = corner_s2[1];
	assign corner_c = corner_s2[2];
	assign corner_d = corner_s2[3];

endmodule
`default_nettype wire
